// ===== hdl/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg
// Types, codes and constants shared by the client session handshake block.
// ----------------------------------------------------------------------------
package csh_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    REG_CHECK_VERSION = 2'd0,
    REG_SIGNUP        = 2'd1,
    REG_SETUP         = 2'd2,
    REG_READY         = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_HELLO       = 3'd0,
    PH_HELLO_OK    = 3'd1,
    PH_SIGNUP_WAIT = 3'd2,
    PH_SETUP_WAIT  = 3'd3,
    PH_READY_PEND  = 3'd4,
    PH_ACTIVE      = 3'd5,
    PH_FAILED      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ACT_INCOMING = 3'd0,
    ACT_SIGNUP   = 3'd1,
    ACT_READY    = 3'd2,
    ACT_APP      = 3'd3,
    ACT_FAIL     = 3'd4,
    ACT_RESTART  = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_FAILED        = 4'd1,
    ERR_ID_ORDER      = 4'd2,
    ERR_HELLO         = 4'd3,
    ERR_SIGNUP_REPLY  = 4'd4,
    ERR_SETUP         = 4'd5,
    ERR_EARLY         = 4'd6,
    ERR_PARSE         = 4'd7,
    ERR_SIGNUP_ORDER  = 4'd8,
    ERR_READY_ORDER   = 4'd9,
    ERR_APP_ORDER     = 4'd10,
    ERR_IDS_EXHAUSTED = 4'd11
  } err_e;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_NOTIFY  = 2'd2;

  localparam logic [1:0] EP_CLIENT = 2'd0;
  localparam logic [1:0] EP_LOBBY  = 2'd1;
  localparam logic [1:0] EP_ROOM   = 2'd2;

  typedef struct packed {
    logic [7:0] check_version;
    logic [7:0] signup;
    logic [7:0] setup;
    logic [7:0] ready;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  msg_kind;
    logic [1:0]  msg_source;
    logic [1:0]  msg_target;
    logic [7:0]  msg_command;
    logic [63:0] msg_id;
    logic [63:0] reply_to_id;
    logic        payload_ok;
    logic        signup_accepted;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  error_code;
    logic [63:0] out_msg_id;
    logic [1:0]  out_kind;
    logic [1:0]  out_target;
    logic [7:0]  out_command;
    logic [2:0]  session_phase;
    logic [63:0] session_generation;
    logic [63:0] last_in_id;
  } res_t;

endpackage

// ===== hdl/csh_if.sv =====
// ----------------------------------------------------------------------------
// csh_if
// Valid/ready channels of the client session handshake: action items in,
// result items out.
// ----------------------------------------------------------------------------
interface csh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  msg_kind;
  logic [1:0]  msg_source;
  logic [1:0]  msg_target;
  logic [7:0]  msg_command;
  logic [63:0] msg_id;
  logic [63:0] reply_to_id;
  logic        payload_ok;
  logic        signup_accepted;

  modport source (
    output valid, action, msg_kind, msg_source, msg_target, msg_command,
           msg_id, reply_to_id, payload_ok, signup_accepted,
    input  ready
  );
  modport sink (
    input  valid, action, msg_kind, msg_source, msg_target, msg_command,
           msg_id, reply_to_id, payload_ok, signup_accepted,
    output ready
  );
endinterface

interface csh_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [3:0]  error_code;
  logic [63:0] out_msg_id;
  logic [1:0]  out_kind;
  logic [1:0]  out_target;
  logic [7:0]  out_command;
  logic [2:0]  session_phase;
  logic [63:0] session_generation;
  logic [63:0] last_in_id;

  modport source (
    output valid, ok, error_code, out_msg_id, out_kind, out_target,
           out_command, session_phase, session_generation, last_in_id,
    input  ready
  );
  modport sink (
    input  valid, ok, error_code, out_msg_id, out_kind, out_target,
           out_command, session_phase, session_generation, last_in_id,
    output ready
  );
endinterface

// ===== hdl/client_session_handshake.sv =====
// ----------------------------------------------------------------------------
// client_session_handshake
// Client side of a session handshake: one action per transaction, one
// result per transaction.
// ----------------------------------------------------------------------------
// usage
//   in_i   : valid/ready channel of actions (incoming header check, signup,
//            ready, application message, fail, restart)
//   out_o  : valid/ready channel of results, one per action, in order
//   apb    : four 8-bit command code registers at byte addresses 0, 4, 8, 12
// path     : an action passes the input register, then the result register,
//            and a stall can hold it in either
// rate     : one transaction per cycle while out_o.ready is high; the
//            session state is updated in the single step stage between
//            the two registers
// reset    : phase awaiting hello, generation and ids zero, id counter at 1,
//            command codes 0, 1, 2, 3; both channels empty
// stall    : the result register holds while out_o.ready is low; one more
//            action waits in the input register, then in_i.ready drops
// ----------------------------------------------------------------------------
module client_session_handshake import csh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  csh_in_if.sink              in_i,
  csh_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_valid_q, in_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  advance;
  logic  in_take;

  csh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csh_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res)
  );

  assign advance     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~in_valid_q | advance;
  assign in_take     = in_i.valid & in_i.ready;
  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action          <= in_i.action;
      item_q.msg_kind        <= in_i.msg_kind;
      item_q.msg_source      <= in_i.msg_source;
      item_q.msg_target      <= in_i.msg_target;
      item_q.msg_command     <= in_i.msg_command;
      item_q.msg_id          <= in_i.msg_id;
      item_q.reply_to_id     <= in_i.reply_to_id;
      item_q.payload_ok      <= in_i.payload_ok;
      item_q.signup_accepted <= in_i.signup_accepted;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.ok                 = res_q.ok;
  assign out_o.error_code         = res_q.error_code;
  assign out_o.out_msg_id         = res_q.out_msg_id;
  assign out_o.out_kind           = res_q.out_kind;
  assign out_o.out_target         = res_q.out_target;
  assign out_o.out_command        = res_q.out_command;
  assign out_o.session_phase      = res_q.session_phase;
  assign out_o.session_generation = res_q.session_generation;
  assign out_o.last_in_id         = res_q.last_in_id;

`ifndef SYNTHESIS
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("waiting action dropped");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result lost or changed");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step taken without a result");
`endif

endmodule

// ===== hdl/csh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csh_cfg_regs
// APB register file holding the four command codes.
// ----------------------------------------------------------------------------
module csh_cfg_regs import csh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CHECK_VERSION: cfg_d.check_version = pwdata[7:0];
        REG_SIGNUP:        cfg_d.signup        = pwdata[7:0];
        REG_SETUP:         cfg_d.setup         = pwdata[7:0];
        REG_READY:         cfg_d.ready         = pwdata[7:0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHECK_VERSION: prdata = {24'd0, cfg_q.check_version};
      REG_SIGNUP:        prdata = {24'd0, cfg_q.signup};
      REG_SETUP:         prdata = {24'd0, cfg_q.setup};
      REG_READY:         prdata = {24'd0, cfg_q.ready};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_version <= 8'd0;
      cfg_q.signup        <= 8'd1;
      cfg_q.setup         <= 8'd2;
      cfg_q.ready         <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/csh_engine.sv =====
// ----------------------------------------------------------------------------
// csh_engine
// Session state and the single-pass step logic: checks one action against
// the current phase, ids and counter, and gives its result and next state.
// ----------------------------------------------------------------------------
module csh_engine import csh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  output res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [63:0] generation_q, generation_d;
  logic [63:0] last_in_q, last_in_d;
  logic [63:0] signup_id_q, signup_id_d;
  logic [63:0] next_id_q, next_id_d;
  logic        exhausted_q, exhausted_d;

  function automatic logic flow_is(item_t it, logic [1:0] kind, logic [7:0] cmd);
    return (it.msg_kind == kind) && (it.msg_source == EP_LOBBY) &&
           (it.msg_target == EP_CLIENT) && (it.msg_command == cmd);
  endfunction

  always_comb begin
    phase_e inc_phase;
    err_e   err;
    logic   take;

    phase_d      = phase_q;
    generation_d = generation_q;
    last_in_d    = last_in_q;
    signup_id_d  = signup_id_q;
    next_id_d    = next_id_q;
    exhausted_d  = exhausted_q;
    inc_phase    = phase_q;
    err          = ERR_NONE;
    take         = 1'b0;
    res_o        = '0;

    case (item_i.action)
      ACT_INCOMING: begin
        if (phase_q == PH_FAILED) begin
          err = ERR_FAILED;
        end else if ((item_i.msg_id == 64'd0) || (item_i.msg_id <= last_in_q)) begin
          err = ERR_ID_ORDER;
        end else begin
          case (phase_q)
            PH_HELLO: begin
              if (!flow_is(item_i, KIND_NOTIFY, cfg_i.check_version)) err = ERR_HELLO;
              else if (!item_i.payload_ok) err = ERR_PARSE;
              else inc_phase = PH_HELLO_OK;
            end
            PH_SIGNUP_WAIT: begin
              if (!flow_is(item_i, KIND_REPLY, cfg_i.signup) ||
                  (item_i.reply_to_id != signup_id_q)) err = ERR_SIGNUP_REPLY;
              else if (!item_i.payload_ok) err = ERR_PARSE;
              else inc_phase = item_i.signup_accepted ? PH_SETUP_WAIT : PH_FAILED;
            end
            PH_SETUP_WAIT: begin
              if (!flow_is(item_i, KIND_NOTIFY, cfg_i.setup)) err = ERR_SETUP;
              else if (!item_i.payload_ok) err = ERR_PARSE;
              else inc_phase = PH_READY_PEND;
            end
            PH_ACTIVE: inc_phase = PH_ACTIVE;
            default:   err = ERR_EARLY;
          endcase
        end
        if (err == ERR_NONE) begin
          phase_d   = inc_phase;
          last_in_d = item_i.msg_id;
          res_o.ok  = 1'b1;
        end
      end
      ACT_SIGNUP: begin
        if (phase_q != PH_HELLO_OK) begin
          err = ERR_SIGNUP_ORDER;
        end else if (exhausted_q) begin
          err = ERR_IDS_EXHAUSTED;
        end else begin
          take              = 1'b1;
          signup_id_d       = next_id_q;
          phase_d           = PH_SIGNUP_WAIT;
          res_o.ok          = 1'b1;
          res_o.out_msg_id  = next_id_q;
          res_o.out_kind    = KIND_REQUEST;
          res_o.out_target  = EP_LOBBY;
          res_o.out_command = cfg_i.signup;
        end
      end
      ACT_READY: begin
        if (phase_q != PH_READY_PEND) begin
          err = ERR_READY_ORDER;
        end else if (exhausted_q) begin
          err = ERR_IDS_EXHAUSTED;
        end else begin
          take              = 1'b1;
          phase_d           = PH_ACTIVE;
          res_o.ok          = 1'b1;
          res_o.out_msg_id  = next_id_q;
          res_o.out_kind    = KIND_NOTIFY;
          res_o.out_target  = EP_ROOM;
          res_o.out_command = cfg_i.ready;
        end
      end
      ACT_APP: begin
        if (phase_q != PH_ACTIVE) begin
          err = ERR_APP_ORDER;
        end else if ((item_i.msg_id == 64'd0) && exhausted_q) begin
          err = ERR_IDS_EXHAUSTED;
        end else begin
          take              = (item_i.msg_id == 64'd0);
          res_o.ok          = 1'b1;
          res_o.out_msg_id  = take ? next_id_q : item_i.msg_id;
          res_o.out_kind    = item_i.msg_kind;
          res_o.out_target  = item_i.msg_target;
          res_o.out_command = item_i.msg_command;
        end
      end
      ACT_FAIL: begin
        phase_d  = PH_FAILED;
        res_o.ok = 1'b1;
      end
      ACT_RESTART: begin
        if (!(&generation_q)) generation_d = generation_q + 64'd1;
        phase_d     = PH_HELLO;
        next_id_d   = 64'd1;
        exhausted_d = 1'b0;
        last_in_d   = '0;
        signup_id_d = '0;
        res_o.ok    = 1'b1;
      end
      default: err = ERR_NONE;
    endcase

    if (take) begin
      if (&next_id_q) exhausted_d = 1'b1;
      else next_id_d = next_id_q + 64'd1;
    end

    res_o.error_code         = err;
    res_o.session_phase      = phase_d;
    res_o.session_generation = generation_d;
    res_o.last_in_id         = last_in_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HELLO;
      generation_q <= '0;
      last_in_q    <= '0;
      signup_id_q  <= '0;
      next_id_q    <= 64'd1;
      exhausted_q  <= 1'b0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      generation_q <= generation_d;
      last_in_q    <= last_in_d;
      signup_id_q  <= signup_id_d;
      next_id_q    <= next_id_d;
      exhausted_q  <= exhausted_d;
    end
  end

`ifndef SYNTHESIS
  a_exhausted_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exhausted_q |-> (&next_id_q))
    else $error("id counter exhausted below its maximum");

  a_generation_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (generation_q >= $past(generation_q)))
    else $error("generation count went down");

  a_signup_id_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SIGNUP_WAIT) |-> (signup_id_q != 64'd0))
    else $error("awaiting signup reply without a signup id");
`endif

endmodule
